[src/csl_pkg.sv]
package csl_pkg;

    // Lexer modes
    typedef enum logic [3:0] {
        M_IDLE, M_NUM, M_IDENT, M_PUNCT, M_STR, M_ESC, M_OCT, M_HEX,
        M_BAD, M_BADESC, M_DONE, M_ERR
    } mode_t;

    // Result kinds
    localparam logic [2:0] K_NUM   = 3'd0;
    localparam logic [2:0] K_SBYTE = 3'd1;
    localparam logic [2:0] K_SEND  = 3'd2;
    localparam logic [2:0] K_IDENT = 3'd3;
    localparam logic [2:0] K_KW    = 3'd4;
    localparam logic [2:0] K_PUNCT = 3'd5;
    localparam logic [2:0] K_EOF   = 3'd6;
    localparam logic [2:0] K_ERR   = 3'd7;

    // Error codes
    localparam logic [1:0] E_INVALID  = 2'd0;
    localparam logic [1:0] E_UNCLOSED = 2'd1;
    localparam logic [1:0] E_EMPTYHEX = 2'd2;

    localparam logic [62:0] NUM_MAX = {63{1'b1}};
    localparam int          MAX_RES = 3;

    // One result record, lengths and offsets already saturated
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [62:0] val;
        logic [4:0]  sym;
        logic [7:0]  sbyte;
        logic [1:0]  err;
    } res_t;

    // Results of one source byte
    typedef struct packed {
        logic [1:0]       cnt;
        res_t [MAX_RES-1:0] rec;
    } step_res_t;

    // Keywords packed big-endian, right-aligned, in index order
    localparam logic [47:0] KW_PACK [8] = '{
        48'h7265_7475_726e, 48'h0000_0000_6966, 48'h0000_656c_7365,
        48'h0000_0066_6f72, 48'h0077_6869_6c65, 48'h0000_0069_6e74,
        48'h7369_7a65_6f66, 48'h0000_6368_6172
    };
    localparam logic [2:0] KW_LEN [8] = '{
        3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd3, 3'd6, 3'd4
    };

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word_lead(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_octal(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h37;
    endfunction

    function automatic logic is_pair_lead(logic [7:0] c);
        return c == 8'h3d || c == 8'h21 || c == 8'h3c || c == 8'h3e;
    endfunction

    // Pair punctuator code from its lead byte
    function automatic logic [4:0] pair_code(logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h3d:   r = 5'd0;
            8'h21:   r = 5'd1;
            8'h3c:   r = 5'd2;
            default: r = 5'd3;
        endcase
        return r;
    endfunction

    // Single punctuator: {valid, code}
    function automatic logic [5:0] single_code(logic [7:0] c);
        logic [5:0] r;
        case (c)
            8'h2b:   r = {1'b1, 5'd4};
            8'h2d:   r = {1'b1, 5'd5};
            8'h2a:   r = {1'b1, 5'd6};
            8'h2f:   r = {1'b1, 5'd7};
            8'h28:   r = {1'b1, 5'd8};
            8'h29:   r = {1'b1, 5'd9};
            8'h3c:   r = {1'b1, 5'd10};
            8'h3e:   r = {1'b1, 5'd11};
            8'h3b:   r = {1'b1, 5'd12};
            8'h3d:   r = {1'b1, 5'd13};
            8'h7b:   r = {1'b1, 5'd14};
            8'h7d:   r = {1'b1, 5'd15};
            8'h26:   r = {1'b1, 5'd16};
            8'h2c:   r = {1'b1, 5'd17};
            8'h5b:   r = {1'b1, 5'd18};
            8'h5d:   r = {1'b1, 5'd19};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    // Hex digit: {valid, value}
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        if (is_digit(c))                    r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)  r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)  r = {1'b1, 4'(c - 8'h37)};
        else                                r = 5'd0;
        return r;
    endfunction

    function automatic logic [7:0] letter_escape(logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h61:   r = 8'd7;
            8'h62:   r = 8'd8;
            8'h74:   r = 8'd9;
            8'h6e:   r = 8'd10;
            8'h76:   r = 8'd11;
            8'h66:   r = 8'd12;
            8'h72:   r = 8'd13;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[src/csl_core.sv]
module csl_core
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] in_byte,
    input  logic       in_fin,
    output step_res_t  step_out
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic has;
        logic bad;
        res_t rec;
    } flush_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] bpos_reg, bpos_next;
    logic [POSITION_BITS-1:0] spos_reg, spos_next;
    logic [62:0]              acc_reg, acc_next;
    logic [47:0]              pfx_reg, pfx_next;
    logic [7:0]               pend_reg, pend_next;
    logic [7:0]               ev_reg, ev_next;
    logic [1:0]               ed_reg, ed_next;
    logic [15:0]              dcnt_reg, dcnt_next;
    logic                     elat_reg, elat_next;

    // Working values of the step
    step_res_t                out_w;
    logic [POSITION_BITS-1:0] pos_w;
    logic                     put_req, flush_req, start_req, str_req, fail_req;
    logic [7:0]               put_val;
    logic [1:0]               fail_code;
    logic [POSITION_BITS-1:0] fail_start;
    logic [66:0]              acc_wide;
    logic [4:0]               hex_w;
    logic [5:0]               sp_w;
    flush_t                   fl_w;

    function automatic logic [15:0] sat16(logic [32:0] v);
        return (v > 33'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic res_t mk(logic [2:0] kind, logic [32:0] st, logic [32:0] ln,
                                logic [62:0] val, logic [4:0] sym, logic [7:0] sb,
                                logic [1:0] err);
        res_t r;
        r.kind  = kind;
        r.start = sat16(st);
        r.len   = sat16(ln);
        r.val   = val;
        r.sym   = sym;
        r.sbyte = sb;
        r.err   = err;
        return r;
    endfunction

    // Close a pending number, identifier or punctuator at pos
    function automatic flush_t flush_f(mode_t m, logic [POSITION_BITS-1:0] sp,
                                       logic [62:0] acc, logic [47:0] pfx,
                                       logic [7:0] pend, logic [POSITION_BITS-1:0] pos);
        flush_t     f;
        logic [32:0] len;
        logic [2:0] kind;
        logic [4:0] sym;
        logic       hit;
        logic [5:0] sc;
        len  = 33'(pos) - 33'(sp);
        f    = '0;
        kind = K_IDENT;
        sym  = 5'd0;
        hit  = 1'b0;
        sc   = single_code(pend);
        case (m)
            M_NUM: begin
                f.has = 1'b1;
                f.rec = mk(K_NUM, 33'(sp), len, acc, 5'd0, 8'd0, 2'd0);
            end
            M_IDENT: begin
                for (int k = 0; k < 8; k++) begin
                    if (!hit && len == 33'(KW_LEN[k]) && pfx == KW_PACK[k]) begin
                        hit  = 1'b1;
                        kind = K_KW;
                        sym  = 5'(k);
                    end
                end
                f.has = 1'b1;
                f.rec = mk(kind, 33'(sp), len, 63'd0, sym, 8'd0, 2'd0);
            end
            M_PUNCT: begin
                if (pend == 8'h21) begin
                    f.bad = 1'b1;
                end else begin
                    f.has = 1'b1;
                    f.rec = mk(K_PUNCT, 33'(sp), 33'd1, 63'd0, sc[4:0],
                               8'd0, 2'd0);
                end
            end
            default: ;
        endcase
        return f;
    endfunction

    // Run one source byte through the lexer
    always_comb begin
        mode_next = mode_reg;
        bpos_next = bpos_reg;
        spos_next = spos_reg;
        acc_next  = acc_reg;
        pfx_next  = pfx_reg;
        pend_next = pend_reg;
        ev_next   = ev_reg;
        ed_next   = ed_reg;
        dcnt_next = dcnt_reg;
        elat_next = elat_reg;
        out_w     = '0;
        pos_w     = bpos_reg;
        put_req   = 1'b0;
        put_val   = 8'd0;
        flush_req = 1'b0;
        start_req = 1'b0;
        str_req   = 1'b0;
        fail_req  = 1'b0;
        fail_code = E_INVALID;
        fail_start = spos_reg;
        acc_wide  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                  + 67'(in_byte - 8'h30);
        hex_w     = hex_val(in_byte);
        sp_w      = single_code(in_byte);
        fl_w      = '0;

        if (elat_reg || mode_reg == M_ERR) begin
            // Repeat the sticky error
            out_w.rec[0] = mk(K_ERR, 33'(spos_reg), 33'd0, 63'd0, 5'd0, 8'd0, ev_reg[1:0]);
            out_w.cnt    = 2'd1;
        end else if (mode_reg != M_DONE) begin
            // Decide the work for this byte
            unique case (mode_reg)
                M_IDLE: start_req = 1'b1;
                M_NUM: begin
                    if (is_digit(in_byte)) begin
                        acc_next = (acc_wide > 67'(NUM_MAX)) ? NUM_MAX : acc_wide[62:0];
                    end else begin
                        flush_req = 1'b1;
                        start_req = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_word_lead(in_byte) || is_digit(in_byte)) begin
                        pfx_next = {pfx_reg[39:0], in_byte};
                    end else begin
                        flush_req = 1'b1;
                        start_req = 1'b1;
                    end
                end
                M_PUNCT: begin
                    if (in_byte == 8'h3d) begin
                        out_w.rec[0] = mk(K_PUNCT, 33'(spos_reg), 33'd2, 63'd0,
                                          pair_code(pend_reg), 8'd0, 2'd0);
                        out_w.cnt    = 2'd1;
                        mode_next    = M_IDLE;
                    end else begin
                        flush_req = 1'b1;
                        start_req = 1'b1;
                    end
                end
                M_STR: str_req = 1'b1;
                M_ESC: begin
                    if (in_byte == 8'd0) begin
                        fail_req  = 1'b1;
                        fail_code = E_UNCLOSED;
                    end else if (is_octal(in_byte)) begin
                        ev_next   = in_byte - 8'h30;
                        ed_next   = 2'd1;
                        mode_next = M_OCT;
                    end else if (in_byte == 8'h78) begin
                        ev_next   = 8'd0;
                        ed_next   = 2'd0;
                        mode_next = M_HEX;
                    end else begin
                        put_req   = 1'b1;
                        put_val   = letter_escape(in_byte);
                        mode_next = M_STR;
                    end
                end
                M_OCT: begin
                    if (is_octal(in_byte)) begin
                        ev_next = {ev_reg[4:0], 3'd0} + (in_byte - 8'h30);
                        ed_next = ed_reg + 2'd1;
                        if (ed_next == 2'd3) begin
                            put_req   = 1'b1;
                            put_val   = ev_next;
                            mode_next = M_STR;
                        end
                    end else if (in_byte == 8'h0a || in_byte == 8'd0) begin
                        fail_req  = 1'b1;
                        fail_code = E_UNCLOSED;
                    end else begin
                        put_req   = 1'b1;
                        put_val   = ev_reg;
                        mode_next = M_STR;
                        str_req   = 1'b1;
                    end
                end
                M_HEX: begin
                    if (hex_w[4]) begin
                        ev_next = {ev_reg[3:0], hex_w[3:0]};
                        ed_next = 2'd1;
                    end else if (in_byte == 8'h0a || in_byte == 8'd0) begin
                        fail_req  = 1'b1;
                        fail_code = E_UNCLOSED;
                    end else if (ed_reg == 2'd0) begin
                        if (in_byte == 8'h22) begin
                            fail_req  = 1'b1;
                            fail_code = E_EMPTYHEX;
                        end else begin
                            mode_next = (in_byte == 8'h5c) ? M_BADESC : M_BAD;
                        end
                    end else begin
                        put_req   = 1'b1;
                        put_val   = ev_reg;
                        mode_next = M_STR;
                        str_req   = 1'b1;
                    end
                end
                M_BAD: begin
                    if (in_byte == 8'h22) begin
                        fail_req  = 1'b1;
                        fail_code = E_EMPTYHEX;
                    end else if (in_byte == 8'h0a || in_byte == 8'd0) begin
                        fail_req  = 1'b1;
                        fail_code = E_UNCLOSED;
                    end else if (in_byte == 8'h5c) begin
                        mode_next = M_BADESC;
                    end
                end
                M_BADESC: begin
                    if (in_byte == 8'd0) begin
                        fail_req  = 1'b1;
                        fail_code = E_UNCLOSED;
                    end else begin
                        mode_next = M_BAD;
                    end
                end
                default: ;
            endcase

            // Emit a decoded string byte
            if (put_req) begin
                out_w.rec[out_w.cnt] = mk(K_SBYTE, 33'(spos_reg), 33'd0, 63'd0, 5'd0,
                                          put_val, 2'd0);
                out_w.cnt = out_w.cnt + 2'd1;
                if (dcnt_next != 16'hFFFF) dcnt_next = dcnt_next + 16'd1;
            end

            // Close the token that this byte ends
            if (flush_req) begin
                fl_w = flush_f(mode_reg, spos_reg, acc_reg, pfx_reg, pend_reg, pos_w);
                if (fl_w.bad) begin
                    fail_req  = 1'b1;
                    fail_code = E_INVALID;
                end else begin
                    out_w.rec[out_w.cnt] = fl_w.rec;
                    out_w.cnt = out_w.cnt + 2'd1;
                    mode_next = M_IDLE;
                end
            end

            // Start a token at this byte
            if (start_req && !fail_req) begin
                if (in_byte == 8'd0) begin
                    out_w.rec[out_w.cnt] = mk(K_EOF, 33'(pos_w), 33'd0, 63'd0, 5'd0,
                                              8'd0, 2'd0);
                    out_w.cnt = out_w.cnt + 2'd1;
                    mode_next = M_DONE;
                end else if (!is_space(in_byte)) begin
                    spos_next = pos_w;
                    if (is_digit(in_byte)) begin
                        acc_next  = 63'(in_byte - 8'h30);
                        mode_next = M_NUM;
                    end else if (in_byte == 8'h22) begin
                        dcnt_next = 16'd0;
                        mode_next = M_STR;
                    end else if (is_word_lead(in_byte)) begin
                        pfx_next  = {40'd0, in_byte};
                        mode_next = M_IDENT;
                    end else if (is_pair_lead(in_byte)) begin
                        pend_next = in_byte;
                        mode_next = M_PUNCT;
                    end else if (sp_w[5]) begin
                        out_w.rec[out_w.cnt] = mk(K_PUNCT, 33'(pos_w), 33'd1, 63'd0,
                                                  sp_w[4:0], 8'd0, 2'd0);
                        out_w.cnt = out_w.cnt + 2'd1;
                    end else begin
                        fail_req   = 1'b1;
                        fail_code  = E_INVALID;
                        fail_start = pos_w;
                    end
                end
            end

            // Handle a plain string body byte
            if (str_req) begin
                if (in_byte == 8'h22) begin
                    out_w.rec[out_w.cnt] = mk(K_SEND, 33'(spos_reg),
                                              33'(pos_w) + 33'd1 - 33'(spos_reg),
                                              63'(dcnt_next), 5'd0, 8'd0, 2'd0);
                    out_w.cnt = out_w.cnt + 2'd1;
                    mode_next = M_IDLE;
                end else if (in_byte == 8'h0a || in_byte == 8'd0) begin
                    fail_req  = 1'b1;
                    fail_code = E_UNCLOSED;
                end else if (in_byte == 8'h5c) begin
                    mode_next = M_ESC;
                end else begin
                    out_w.rec[out_w.cnt] = mk(K_SBYTE, 33'(spos_reg), 33'd0, 63'd0, 5'd0,
                                              in_byte, 2'd0);
                    out_w.cnt = out_w.cnt + 2'd1;
                    if (dcnt_next != 16'hFFFF) dcnt_next = dcnt_next + 16'd1;
                end
            end

            // Latch an error
            if (fail_req) begin
                elat_next = 1'b1;
                ev_next   = {6'd0, fail_code};
                spos_next = fail_start;
                mode_next = M_ERR;
                out_w.rec[out_w.cnt] = mk(K_ERR, 33'(fail_start), 33'd0, 63'd0, 5'd0,
                                          8'd0, fail_code);
                out_w.cnt = out_w.cnt + 2'd1;
            end

            // Advance the saturating byte position
            if (bpos_reg != POS_MAX) bpos_next = bpos_reg + POS_ONE;

            // Close everything on the final byte
            if (in_fin && mode_next != M_DONE && mode_next != M_ERR) begin
                fl_w = flush_f(mode_next, spos_next, acc_next, pfx_next, pend_next,
                               bpos_next);
                if (fl_w.bad) begin
                    elat_next = 1'b1;
                    ev_next   = {6'd0, E_INVALID};
                    mode_next = M_ERR;
                    if (out_w.cnt != 2'd3) begin
                        out_w.rec[out_w.cnt] = mk(K_ERR, 33'(spos_next), 33'd0, 63'd0,
                                                  5'd0, 8'd0, E_INVALID);
                        out_w.cnt = out_w.cnt + 2'd1;
                    end
                end else if (fl_w.has) begin
                    mode_next = M_IDLE;
                    if (out_w.cnt != 2'd3) begin
                        out_w.rec[out_w.cnt] = fl_w.rec;
                        out_w.cnt = out_w.cnt + 2'd1;
                    end
                end
                if (mode_next == M_STR || mode_next == M_ESC || mode_next == M_OCT ||
                    mode_next == M_HEX || mode_next == M_BAD || mode_next == M_BADESC) begin
                    elat_next = 1'b1;
                    ev_next   = {6'd0, E_UNCLOSED};
                    mode_next = M_ERR;
                    if (out_w.cnt != 2'd3) begin
                        out_w.rec[out_w.cnt] = mk(K_ERR, 33'(spos_next), 33'd0, 63'd0,
                                                  5'd0, 8'd0, E_UNCLOSED);
                        out_w.cnt = out_w.cnt + 2'd1;
                    end
                end else if (mode_next != M_ERR) begin
                    mode_next = M_DONE;
                    if (out_w.cnt != 2'd3) begin
                        out_w.rec[out_w.cnt] = mk(K_EOF, 33'(bpos_next), 33'd0, 63'd0,
                                                  5'd0, 8'd0, 2'd0);
                        out_w.cnt = out_w.cnt + 2'd1;
                    end
                end
            end
        end
    end

    assign step_out = out_w;

    // Hold lexer state, update on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            bpos_reg <= '0;
            spos_reg <= '0;
            acc_reg  <= '0;
            pfx_reg  <= '0;
            pend_reg <= '0;
            ev_reg   <= '0;
            ed_reg   <= '0;
            dcnt_reg <= '0;
            elat_reg <= 1'b0;
        end else if (step_en) begin
            mode_reg <= mode_next;
            bpos_reg <= bpos_next;
            spos_reg <= spos_next;
            acc_reg  <= acc_next;
            pfx_reg  <= pfx_next;
            pend_reg <= pend_next;
            ev_reg   <= ev_next;
            ed_reg   <= ed_next;
            dcnt_reg <= dcnt_next;
            elat_reg <= elat_next;
        end
    end

endmodule

[src/c_subset_lexer.sv]
// Streaming lexer for a small C subset.
// Slave side: one source byte per transaction on s_tdata, s_tlast marks the
// final byte of the source (a NUL byte also ends it).
// Master side: token records. m_tuser carries the record kind, m_tdata the
// record fields, m_tlast marks the final record caused by one source byte.
// A source byte causes zero to three records. The byte is decoded in the
// cycle it is accepted and its records appear on the master side in the
// cycle after, one per cycle while m_tready is high. A byte with at most one
// record sustains one transaction per cycle while the receiver takes each
// record; a byte with more records holds the output until the single record
// port has drained the result buffer. s_tready stays high while the buffer
// holds at most one record that is being taken, so a stalled receiver holds
// back the source after one byte. Reset clears all lexer state, the byte
// position and the sticky error, and empties the result buffer; the block
// accepts bytes in the first cycle after reset.
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_byte
    input  logic         s_tlast,   // end_of_input
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // token_start, token_length, number_value,
                                    // symbol_code, string_byte, error_code, zero pad
    output logic [2:0]   m_tuser,   // result_kind
    output logic         m_tlast    // last_of_run
);

    step_res_t          core_out;
    res_t [MAX_RES-1:0] buf_reg, buf_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               in_acc, out_acc;

    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    csl_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (in_acc),
        .in_byte  (s_tdata),
        .in_fin   (s_tlast),
        .step_out (core_out)
    );

    // Load a new byte's records or shift out the one taken
    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (in_acc) begin
            buf_next = core_out.rec;
            cnt_next = core_out.cnt;
        end else if (out_acc) begin
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    // Drive the head record
    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tlast  = cnt_reg == 2'd1;
    assign m_tuser  = buf_reg[0].kind;
    assign m_tdata  = {2'b00, buf_reg[0].err, buf_reg[0].sbyte, buf_reg[0].sym,
                       buf_reg[0].val, buf_reg[0].len, buf_reg[0].start};

    // Accept only when the buffer empties this cycle
    a_ready_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |-> (cnt_reg == 2'd0 || out_acc))
        else $error("byte accepted while records still pending");

    // A byte with no records leaves the output idle
    a_empty_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && core_out.cnt == 2'd0) |=> !m_tvalid)
        else $error("record shown for a byte that made none");

    // Remaining records of a byte stay offered
    a_keep_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && cnt_reg > 2'd1) |=> (m_tvalid && !s_tready || m_tvalid))
        else $error("records lost after a transaction");

    // A multi-record byte blocks new input until its last record
    a_block_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !s_tready)
        else $error("input open while several records wait");

endmodule
